@@ hw/rtl/mrs_pkg.sv @@
// Shared types, constants and the CRC step of the Modbus RTU register server.
package mrs_pkg;

   localparam int RegCount        = 64;
   localparam int RegAddrWidth    = $clog2(RegCount);
   localparam int RxBufferBytes   = 256;
   localparam int RxAddrWidth     = $clog2(RxBufferBytes);
   localparam int TxBufferBytes   = 256;
   localparam int TxAddrWidth     = $clog2(TxBufferBytes);
   localparam int MaxReadRegs     = 125;

   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [7:0]  FN_READ_HOLDING = 8'd3;
   localparam logic [7:0]  FN_WRITE_MULTI  = 8'd16;
   localparam logic [7:0]  FN_EXC_FLAG     = 8'h80;
   localparam logic [7:0]  BROADCAST_ADDR  = 8'd0;
   localparam logic [7:0]  SLAVE_ADDR_RST  = 8'd1;

   localparam logic [2:0] STATUS_NONE  = 3'd0;
   localparam logic [2:0] STATUS_DROP  = 3'd1;
   localparam logic [2:0] STATUS_OTHER = 3'd2;
   localparam logic [2:0] STATUS_REPLY = 3'd3;
   localparam logic [2:0] STATUS_BCAST = 3'd4;

   localparam logic [1:0] EXC_NONE             = 2'd0;
   localparam logic [1:0] EXC_ILLEGAL_FUNCTION = 2'd1;
   localparam logic [1:0] EXC_ILLEGAL_ADDRESS  = 2'd2;

   typedef enum logic [1:0] {
      CMD_RX_BYTE,
      CMD_GAP,
      CMD_PULL,
      CMD_HOST_READ
   } command_type;

   typedef struct packed {
      command_type       command;
      logic [7:0]        rx_byte;
      logic [5:0]        reg_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic        tx_last;
      logic [2:0]  frame_status;
      logic [1:0]  exception_code;
      logic        regs_written;
      logic [15:0] reg_data;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RX_BYTE,
      OP_CRC_INIT,
      OP_RX_RD,
      OP_RX_CRC,
      OP_TX_INIT,
      OP_TX_PUT,
      OP_HR_RD,
      OP_RX_RD_W,
      OP_HI_CAP,
      OP_HR_WR,
      OP_GAP_DONE,
      OP_PULL_RD,
      OP_PULL_OUT,
      OP_HOST_RD,
      OP_HOST_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      SRC_ID,
      SRC_FN,
      SRC_FN_EXC,
      SRC_EXC,
      SRC_HDR,
      SRC_QTY2,
      SRC_HR_HI,
      SRC_HR_LO,
      SRC_CRC_LO,
      SRC_CRC_HI
   } tx_src_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GAP_CHK,
      ST_CRC_RD,
      ST_CRC_UPD,
      ST_DECIDE,
      ST_EX_ID,
      ST_EX_FN,
      ST_EX_CODE,
      ST_RD_ID,
      ST_RD_FN,
      ST_RD_CNT,
      ST_RD_REQ,
      ST_RD_HI,
      ST_RD_LO,
      ST_WR_RA,
      ST_WR_RB,
      ST_WR_WR,
      ST_WR_CHK,
      ST_WE_ID,
      ST_WE_FN,
      ST_WE_HDR,
      ST_SEAL_LO,
      ST_SEAL_HI,
      ST_REPLY_DONE,
      ST_PULL,
      ST_HOST
   } state_type;

   typedef struct packed {
      dp_op_type  op;
      tx_src_type src;
      logic [2:0] status;
      logic [1:0] exc;
   } dp_cmd_type;

   typedef struct packed {
      logic rx_empty;
      logic rx_short;
      logic idx_last;
      logic crc_ok;
      logic addr_ok;
      logic bcast;
      logic fn_read;
      logic fn_write;
      logic cnt_lt8;
      logic write_short;
      logic read_bad;
      logic write_bad;
      logic rc_done;
      logic hdr_last;
   } dp_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/mrs_datapath.sv @@
// Datapath of the register server: buffers, holding registers, CRC and result register.
module mrs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mrs_pkg::req_type      req_item,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data,
   input  mrs_pkg::dp_cmd_type   cmd,
   output mrs_pkg::dp_status_type stat,
   output mrs_pkg::rsp_type      rsp_item,
   output logic                  rsp_strobe
);

   localparam int RxAddrW = mrs_pkg::RxAddrWidth;

   logic [7:0]  rx_mem [0:mrs_pkg::RxBufferBytes-1];
   logic [7:0]  tx_mem [0:mrs_pkg::TxBufferBytes-1];
   logic [15:0] hr_mem [0:mrs_pkg::RegCount-1];

   logic [7:0]  slave_ff;
   logic [8:0]  rx_count_ff;
   logic        rx_ovf_ff;
   logic [8:0]  idx_ff;
   logic [15:0] crc_ff;
   logic [7:0]  hdr_ff [0:5];
   logic [7:0]  hi_ff;
   logic [6:0]  rc_ff;
   logic [8:0]  tw_ff;
   logic [8:0]  tx_len_ff;
   logic [8:0]  tx_ptr_ff;
   logic [1:0]  exc_ff;
   logic        wr_ff;
   logic [7:0]  rx_q_ff;
   logic [15:0] hr_q_ff;
   logic        hr_vq_ff;
   logic [7:0]  tx_q_ff;
   logic        pull_ok_ff;
   logic        pull_last_ff;
   logic [mrs_pkg::RegCount-1:0] hr_valid_ff;
   mrs_pkg::rsp_type rsp_ff;
   logic        strobe_ff;

   logic [RxAddrW-1:0] rx_raddr;
   logic [mrs_pkg::RegAddrWidth-1:0] hr_addr;
   logic [15:0] start_w;
   logic [15:0] qty_w;
   logic [16:0] end_w;
   logic [17:0] need_w;
   logic [15:0] hr_word;
   logic [7:0]  put_byte;
   logic        rx_rd_en;

   assign start_w = {hdr_ff[2], hdr_ff[3]};
   assign qty_w   = {hdr_ff[4], hdr_ff[5]};
   assign end_w   = {1'b0, start_w} + {1'b0, qty_w};
   assign need_w  = 18'd9 + {1'b0, qty_w, 1'b0};
   assign hr_word = hr_vq_ff ? hr_q_ff : 16'h0000;
   assign hr_addr = start_w[mrs_pkg::RegAddrWidth-1:0] + rc_ff[mrs_pkg::RegAddrWidth-1:0];

   always_comb begin
      rx_rd_en = 1'b1;
      unique case (cmd.op)
         mrs_pkg::OP_RX_RD:   rx_raddr = idx_ff[RxAddrW-1:0];
         mrs_pkg::OP_RX_RD_W: rx_raddr = RxAddrW'(9'd7 + {1'b0, rc_ff, 1'b0});
         mrs_pkg::OP_HI_CAP:  rx_raddr = RxAddrW'(9'd8 + {1'b0, rc_ff, 1'b0});
         default: begin
            rx_raddr = idx_ff[RxAddrW-1:0];
            rx_rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.src)
         mrs_pkg::SRC_ID:     put_byte = hdr_ff[0];
         mrs_pkg::SRC_FN:     put_byte = hdr_ff[1];
         mrs_pkg::SRC_FN_EXC: put_byte = hdr_ff[1] | mrs_pkg::FN_EXC_FLAG;
         mrs_pkg::SRC_EXC:    put_byte = {6'b0, exc_ff};
         mrs_pkg::SRC_HDR:    put_byte = hdr_ff[tw_ff[2:0]];
         mrs_pkg::SRC_QTY2:   put_byte = {hdr_ff[5][6:0], 1'b0};
         mrs_pkg::SRC_HR_HI:  put_byte = hr_word[15:8];
         mrs_pkg::SRC_HR_LO:  put_byte = hr_word[7:0];
         mrs_pkg::SRC_CRC_LO: put_byte = crc_ff[7:0];
         mrs_pkg::SRC_CRC_HI: put_byte = crc_ff[15:8];
         default:             put_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mrs_pkg::OP_RX_BYTE && rx_count_ff < 9'(mrs_pkg::RxBufferBytes)) begin
         rx_mem[rx_count_ff[RxAddrW-1:0]] <= req_item.rx_byte;
      end
      if (rx_rd_en) begin
         rx_q_ff <= rx_mem[rx_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mrs_pkg::OP_TX_PUT) begin
         tx_mem[tw_ff[mrs_pkg::TxAddrWidth-1:0]] <= put_byte;
      end
      if (cmd.op == mrs_pkg::OP_PULL_RD) begin
         tx_q_ff <= tx_mem[tx_ptr_ff[mrs_pkg::TxAddrWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mrs_pkg::OP_HR_WR) begin
         hr_mem[hr_addr] <= {hi_ff, rx_q_ff};
      end
      if (cmd.op == mrs_pkg::OP_HR_RD) begin
         hr_q_ff  <= hr_mem[hr_addr];
         hr_vq_ff <= hr_valid_ff[hr_addr];
      end else if (cmd.op == mrs_pkg::OP_HOST_RD) begin
         hr_q_ff  <= hr_mem[req_item.reg_index];
         hr_vq_ff <= hr_valid_ff[req_item.reg_index] &&
                     ({1'b0, req_item.reg_index} < 7'(mrs_pkg::RegCount));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff    <= mrs_pkg::SLAVE_ADDR_RST;
         rx_count_ff <= '0;
         rx_ovf_ff   <= 1'b0;
         tx_len_ff   <= '0;
         tx_ptr_ff   <= '0;
         hr_valid_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            slave_ff <= csr_write_data;
         end
         strobe_ff <= (cmd.op == mrs_pkg::OP_RX_BYTE) || (cmd.op == mrs_pkg::OP_GAP_DONE) ||
                      (cmd.op == mrs_pkg::OP_PULL_OUT) || (cmd.op == mrs_pkg::OP_HOST_OUT);
         case (cmd.op)
            mrs_pkg::OP_RX_BYTE: begin
               if (rx_count_ff < 9'(mrs_pkg::RxBufferBytes)) begin
                  rx_count_ff <= rx_count_ff + 9'd1;
               end else begin
                  rx_ovf_ff <= 1'b1;
               end
            end
            mrs_pkg::OP_HR_WR: hr_valid_ff[hr_addr] <= 1'b1;
            mrs_pkg::OP_GAP_DONE: begin
               rx_count_ff <= '0;
               rx_ovf_ff   <= 1'b0;
               if (cmd.status == mrs_pkg::STATUS_REPLY) begin
                  tx_len_ff <= tw_ff;
                  tx_ptr_ff <= '0;
               end
            end
            mrs_pkg::OP_PULL_RD: begin
               if (tx_ptr_ff < tx_len_ff) begin
                  tx_ptr_ff <= tx_ptr_ff + 9'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         mrs_pkg::OP_CRC_INIT: begin
            crc_ff <= mrs_pkg::CRC_INIT;
            idx_ff <= '0;
            rc_ff  <= '0;
            wr_ff  <= 1'b0;
         end
         mrs_pkg::OP_RX_CRC: begin
            crc_ff <= mrs_pkg::crc_byte(crc_ff, rx_q_ff);
            if (idx_ff < 9'd6) begin
               hdr_ff[idx_ff[2:0]] <= rx_q_ff;
            end
            idx_ff <= idx_ff + 9'd1;
         end
         mrs_pkg::OP_TX_INIT: begin
            crc_ff <= mrs_pkg::CRC_INIT;
            tw_ff  <= '0;
            exc_ff <= cmd.exc;
         end
         mrs_pkg::OP_TX_PUT: begin
            tw_ff <= tw_ff + 9'd1;
            if (cmd.src != mrs_pkg::SRC_CRC_LO && cmd.src != mrs_pkg::SRC_CRC_HI) begin
               crc_ff <= mrs_pkg::crc_byte(crc_ff, put_byte);
            end
         end
         mrs_pkg::OP_HR_RD: rc_ff <= rc_ff + 7'd1;
         mrs_pkg::OP_HI_CAP: hi_ff <= rx_q_ff;
         mrs_pkg::OP_HR_WR: begin
            rc_ff <= rc_ff + 7'd1;
            wr_ff <= 1'b1;
         end
         mrs_pkg::OP_PULL_RD: begin
            pull_ok_ff   <= tx_ptr_ff < tx_len_ff;
            pull_last_ff <= (tx_ptr_ff + 9'd1) == tx_len_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         mrs_pkg::OP_RX_BYTE: rsp_ff <= '0;
         mrs_pkg::OP_GAP_DONE: begin
            rsp_ff                <= '0;
            rsp_ff.frame_status   <= cmd.status;
            rsp_ff.exception_code <= (cmd.status == mrs_pkg::STATUS_REPLY) ? exc_ff
                                                                           : mrs_pkg::EXC_NONE;
            rsp_ff.regs_written   <= wr_ff && (cmd.status == mrs_pkg::STATUS_REPLY ||
                                               cmd.status == mrs_pkg::STATUS_BCAST);
         end
         mrs_pkg::OP_PULL_OUT: begin
            rsp_ff          <= '0;
            rsp_ff.tx_valid <= pull_ok_ff;
            rsp_ff.tx_last  <= pull_ok_ff && pull_last_ff;
            rsp_ff.tx_byte  <= pull_ok_ff ? tx_q_ff : 8'h00;
         end
         mrs_pkg::OP_HOST_OUT: begin
            rsp_ff          <= '0;
            rsp_ff.reg_data <= hr_word;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.rx_empty    = (rx_count_ff == 9'd0) && !rx_ovf_ff;
      stat.rx_short    = rx_ovf_ff || (rx_count_ff < 9'd4);
      stat.idx_last    = ({1'b0, idx_ff} + 10'd1) == {1'b0, rx_count_ff};
      stat.crc_ok      = crc_ff == 16'h0000;
      stat.bcast       = hdr_ff[0] == mrs_pkg::BROADCAST_ADDR;
      stat.addr_ok     = stat.bcast || (hdr_ff[0] == slave_ff);
      stat.fn_read     = hdr_ff[1] == mrs_pkg::FN_READ_HOLDING;
      stat.fn_write    = hdr_ff[1] == mrs_pkg::FN_WRITE_MULTI;
      stat.cnt_lt8     = rx_count_ff < 9'd8;
      stat.write_short = {9'b0, rx_count_ff} < need_w;
      stat.write_bad   = (qty_w == 16'd0) || (end_w > 17'(mrs_pkg::RegCount));
      stat.read_bad    = stat.write_bad || (qty_w > 16'(mrs_pkg::MaxReadRegs));
      stat.rc_done     = {9'b0, rc_ff} == qty_w;
      stat.hdr_last    = tw_ff == 9'd5;
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

@@ hw/rtl/mrs_ctrl.sv @@
// Controller state machine that sequences requests, frame checks and reply assembly.
module mrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mrs_pkg::command_type   command,
   input  mrs_pkg::dp_status_type stat,
   output mrs_pkg::dp_cmd_type    cmd,
   output logic                   busy
);

   mrs_pkg::state_type state_ff;
   mrs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = mrs_pkg::OP_NONE;
      cmd.src    = mrs_pkg::SRC_ID;
      cmd.status = mrs_pkg::STATUS_NONE;
      cmd.exc    = mrs_pkg::EXC_NONE;
      unique case (state_ff)
         mrs_pkg::ST_IDLE: begin
            if (start) begin
               unique case (command)
                  mrs_pkg::CMD_RX_BYTE: cmd.op = mrs_pkg::OP_RX_BYTE;
                  mrs_pkg::CMD_GAP: begin
                     cmd.op   = mrs_pkg::OP_CRC_INIT;
                     state_in = mrs_pkg::ST_GAP_CHK;
                  end
                  mrs_pkg::CMD_PULL: begin
                     cmd.op   = mrs_pkg::OP_PULL_RD;
                     state_in = mrs_pkg::ST_PULL;
                  end
                  mrs_pkg::CMD_HOST_READ: begin
                     cmd.op   = mrs_pkg::OP_HOST_RD;
                     state_in = mrs_pkg::ST_HOST;
                  end
                  default: ;
               endcase
            end
         end
         mrs_pkg::ST_GAP_CHK: begin
            if (stat.rx_empty) begin
               cmd.op     = mrs_pkg::OP_GAP_DONE;
               cmd.status = mrs_pkg::STATUS_NONE;
               state_in   = mrs_pkg::ST_IDLE;
            end else if (stat.rx_short) begin
               cmd.op     = mrs_pkg::OP_GAP_DONE;
               cmd.status = mrs_pkg::STATUS_DROP;
               state_in   = mrs_pkg::ST_IDLE;
            end else begin
               state_in = mrs_pkg::ST_CRC_RD;
            end
         end
         mrs_pkg::ST_CRC_RD: begin
            cmd.op   = mrs_pkg::OP_RX_RD;
            state_in = mrs_pkg::ST_CRC_UPD;
         end
         mrs_pkg::ST_CRC_UPD: begin
            cmd.op   = mrs_pkg::OP_RX_CRC;
            state_in = stat.idx_last ? mrs_pkg::ST_DECIDE : mrs_pkg::ST_CRC_RD;
         end
         mrs_pkg::ST_DECIDE: begin
            cmd.op   = mrs_pkg::OP_GAP_DONE;
            state_in = mrs_pkg::ST_IDLE;
            if (!stat.crc_ok) begin
               cmd.status = mrs_pkg::STATUS_DROP;
            end else if (!stat.addr_ok) begin
               cmd.status = mrs_pkg::STATUS_OTHER;
            end else if (!stat.fn_read && !stat.fn_write) begin
               if (stat.bcast) begin
                  cmd.status = mrs_pkg::STATUS_BCAST;
               end else begin
                  cmd.op   = mrs_pkg::OP_TX_INIT;
                  cmd.exc  = mrs_pkg::EXC_ILLEGAL_FUNCTION;
                  state_in = mrs_pkg::ST_EX_ID;
               end
            end else if (stat.cnt_lt8) begin
               cmd.status = mrs_pkg::STATUS_DROP;
            end else if (stat.fn_read) begin
               if (stat.bcast) begin
                  cmd.status = mrs_pkg::STATUS_BCAST;
               end else if (stat.read_bad) begin
                  cmd.op   = mrs_pkg::OP_TX_INIT;
                  cmd.exc  = mrs_pkg::EXC_ILLEGAL_ADDRESS;
                  state_in = mrs_pkg::ST_EX_ID;
               end else begin
                  cmd.op   = mrs_pkg::OP_TX_INIT;
                  state_in = mrs_pkg::ST_RD_ID;
               end
            end else if (stat.write_short) begin
               cmd.status = mrs_pkg::STATUS_DROP;
            end else if (stat.write_bad) begin
               if (stat.bcast) begin
                  cmd.status = mrs_pkg::STATUS_BCAST;
               end else begin
                  cmd.op   = mrs_pkg::OP_TX_INIT;
                  cmd.exc  = mrs_pkg::EXC_ILLEGAL_ADDRESS;
                  state_in = mrs_pkg::ST_EX_ID;
               end
            end else begin
               cmd.op   = mrs_pkg::OP_NONE;
               state_in = mrs_pkg::ST_WR_RA;
            end
         end
         mrs_pkg::ST_EX_ID: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_ID;
            state_in = mrs_pkg::ST_EX_FN;
         end
         mrs_pkg::ST_EX_FN: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_FN_EXC;
            state_in = mrs_pkg::ST_EX_CODE;
         end
         mrs_pkg::ST_EX_CODE: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_EXC;
            state_in = mrs_pkg::ST_SEAL_LO;
         end
         mrs_pkg::ST_RD_ID: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_ID;
            state_in = mrs_pkg::ST_RD_FN;
         end
         mrs_pkg::ST_RD_FN: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_FN;
            state_in = mrs_pkg::ST_RD_CNT;
         end
         mrs_pkg::ST_RD_CNT: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_QTY2;
            state_in = mrs_pkg::ST_RD_REQ;
         end
         mrs_pkg::ST_RD_REQ: begin
            cmd.op   = mrs_pkg::OP_HR_RD;
            state_in = mrs_pkg::ST_RD_HI;
         end
         mrs_pkg::ST_RD_HI: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_HR_HI;
            state_in = mrs_pkg::ST_RD_LO;
         end
         mrs_pkg::ST_RD_LO: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_HR_LO;
            state_in = stat.rc_done ? mrs_pkg::ST_SEAL_LO : mrs_pkg::ST_RD_REQ;
         end
         mrs_pkg::ST_WR_RA: begin
            cmd.op   = mrs_pkg::OP_RX_RD_W;
            state_in = mrs_pkg::ST_WR_RB;
         end
         mrs_pkg::ST_WR_RB: begin
            cmd.op   = mrs_pkg::OP_HI_CAP;
            state_in = mrs_pkg::ST_WR_WR;
         end
         mrs_pkg::ST_WR_WR: begin
            cmd.op   = mrs_pkg::OP_HR_WR;
            state_in = mrs_pkg::ST_WR_CHK;
         end
         mrs_pkg::ST_WR_CHK: begin
            if (!stat.rc_done) begin
               state_in = mrs_pkg::ST_WR_RA;
            end else if (stat.bcast) begin
               cmd.op     = mrs_pkg::OP_GAP_DONE;
               cmd.status = mrs_pkg::STATUS_BCAST;
               state_in   = mrs_pkg::ST_IDLE;
            end else begin
               cmd.op   = mrs_pkg::OP_TX_INIT;
               state_in = mrs_pkg::ST_WE_ID;
            end
         end
         mrs_pkg::ST_WE_ID: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_ID;
            state_in = mrs_pkg::ST_WE_FN;
         end
         mrs_pkg::ST_WE_FN: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_FN;
            state_in = mrs_pkg::ST_WE_HDR;
         end
         mrs_pkg::ST_WE_HDR: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_HDR;
            state_in = stat.hdr_last ? mrs_pkg::ST_SEAL_LO : mrs_pkg::ST_WE_HDR;
         end
         mrs_pkg::ST_SEAL_LO: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_CRC_LO;
            state_in = mrs_pkg::ST_SEAL_HI;
         end
         mrs_pkg::ST_SEAL_HI: begin
            cmd.op   = mrs_pkg::OP_TX_PUT;
            cmd.src  = mrs_pkg::SRC_CRC_HI;
            state_in = mrs_pkg::ST_REPLY_DONE;
         end
         mrs_pkg::ST_REPLY_DONE: begin
            cmd.op     = mrs_pkg::OP_GAP_DONE;
            cmd.status = mrs_pkg::STATUS_REPLY;
            state_in   = mrs_pkg::ST_IDLE;
         end
         mrs_pkg::ST_PULL: begin
            cmd.op   = mrs_pkg::OP_PULL_OUT;
            state_in = mrs_pkg::ST_IDLE;
         end
         mrs_pkg::ST_HOST: begin
            cmd.op   = mrs_pkg::OP_HOST_OUT;
            state_in = mrs_pkg::ST_IDLE;
         end
         default: state_in = mrs_pkg::ST_IDLE;
      endcase
   end

   assign busy = state_ff != mrs_pkg::ST_IDLE;

endmodule

@@ hw/rtl/modbus_rtu_slave_register_server.sv @@
// Top level of the Modbus RTU slave holding-register server.
//
//   channel   ports                                   handshake
//   request   start, busy, req_item                   taken when start is high and busy low
//   response  rsp_strobe, rsp_item                    one cycle per result, no back-pressure
//   config    csr_write_enable, csr_write_data        written on any enabled edge out of reset
//
// A received byte is taken straight from idle; a pull or a host read passes through
// its own output state. A gap walks the CRC with a read and an update state per
// received byte, then takes request, high and low states per register read, read,
// capture, write and check states per register written, and a put per other reply byte.
// Reset clears counters, the reply pointer and the register valid bits at once.
// Each result appears in the cycle after the last step of its request; the
// receiver cannot stall it, so only busy holds off new requests.
module modbus_rtu_slave_register_server (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mrs_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output mrs_pkg::rsp_type  rsp_item,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   mrs_pkg::dp_cmd_type    cmd;
   mrs_pkg::dp_status_type stat;

   mrs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_item.command),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   mrs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_item         (rsp_item),
      .rsp_strobe       (rsp_strobe)
   );

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while the controller is busy");

   a_byte_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.command == mrs_pkg::CMD_RX_BYTE) |=> rsp_strobe)
      else $error("received byte produced no result");

   a_exc_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.exception_code != mrs_pkg::EXC_NONE) |->
      (rsp_item.frame_status == mrs_pkg::STATUS_REPLY))
      else $error("exception code without a queued reply");

   a_tx_only_pull: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.tx_valid) |-> (rsp_item.frame_status == mrs_pkg::STATUS_NONE))
      else $error("reply byte mixed with a frame status");

endmodule
